// ===== rtl/fqp_pkg.sv =====
// ----------------------------------------------------------------------------
// FASTA/FASTQ parser package
// Shared types and character constants for the record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fqp_pkg;

  // Parser phase
  typedef enum logic [3:0] {
    PH_DETECT     = 4'd0,
    PH_PRE_LABEL  = 4'd1,
    PH_LABEL      = 4'd2,
    PH_POST_LABEL = 4'd3,
    PH_SEQ        = 4'd4,
    PH_PLUS       = 4'd5,
    PH_SCORE      = 4'd6,
    PH_DONE       = 4'd7,
    PH_BAD        = 4'd8,
    PH_UNKNOWN    = 4'd9
  } phase_t;

  // Result kinds
  localparam logic [2:0] K_LABEL     = 3'd0;
  localparam logic [2:0] K_SEQ       = 3'd1;
  localparam logic [2:0] K_EMPTY     = 3'd2;
  localparam logic [2:0] K_END       = 3'd3;
  localparam logic [2:0] K_PARSE_ERR = 3'd4;
  localparam logic [2:0] K_UNKNOWN   = 3'd5;

  // Characters
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_AT    = 8'h40;  // '@'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_NL    = 8'h0A;  // newline
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  value;
    logic [31:0] seq_length;
    logic        format;
  } result_t;

  // Results produced by one input byte
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } step_out_t;

endpackage

`default_nettype wire

// ===== rtl/fqp_step.sv =====
// ----------------------------------------------------------------------------
// Parser step logic
// Next state and result items for one input byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fqp_step
  import fqp_pkg::*;
#(
  parameter int LABEL_LIMIT = 256,
  parameter int COUNT_WIDTH = 32,
  parameter int LW          = $clog2(LABEL_LIMIT)
) (
  input  wire logic [7:0]             byte_in,
  input  wire logic                   last_in,
  input  wire phase_t                 phase,
  input  wire logic                   file_kind,
  input  wire logic [LW-1:0]          label_count,
  input  wire logic [COUNT_WIDTH-1:0] seq_count,
  input  wire logic [COUNT_WIDTH-1:0] qual_count,
  output phase_t                      phase_nxt,
  output logic                        file_kind_nxt,
  output logic [LW-1:0]               label_count_nxt,
  output logic [COUNT_WIDTH-1:0]      seq_count_nxt,
  output logic [COUNT_WIDTH-1:0]      qual_count_nxt,
  output step_out_t                   step_out
);

  localparam logic [LW-1:0] LABEL_MAX = LW'(LABEL_LIMIT - 1);

  // Clamp a count to 32 bits
  function automatic logic [31:0] sat32(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+31:0] wide;
    wide = {32'd0, v};
    return (|wide[COUNT_WIDTH+31:32]) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  logic    fasta;
  logic    fin_ok;
  logic    a_vld;
  logic    b_vld;
  result_t a_res;
  result_t b_res;

  assign fasta = (file_kind == 1'b0);

  always_comb begin
    phase_nxt       = phase;
    file_kind_nxt   = file_kind;
    label_count_nxt = label_count;
    seq_count_nxt   = seq_count;
    qual_count_nxt  = qual_count;
    fin_ok          = 1'b1;
    a_vld           = 1'b0;
    b_vld           = 1'b0;
    a_res           = '0;
    b_res           = '0;

    unique case (phase)
      PH_DETECT: begin
        if (byte_in == CH_GT || byte_in == CH_AT) begin
          file_kind_nxt   = (byte_in == CH_AT);
          label_count_nxt = '0;
          seq_count_nxt   = '0;
          qual_count_nxt  = '0;
          phase_nxt       = PH_PRE_LABEL;
        end else if (byte_in != CH_SPACE) begin
          phase_nxt  = PH_UNKNOWN;
          a_vld      = 1'b1;
          a_res.kind = K_UNKNOWN;
          fin_ok     = 1'b0;
        end
      end
      PH_PRE_LABEL, PH_LABEL: begin
        if (byte_in == CH_NL) begin
          phase_nxt = PH_SEQ;
          if (phase == PH_PRE_LABEL) begin
            a_vld      = 1'b1;
            a_res.kind = K_EMPTY;
          end
        end else if (phase == PH_PRE_LABEL && byte_in == CH_SPACE) begin
          phase_nxt = PH_PRE_LABEL;
        end else if (phase == PH_LABEL && byte_in == CH_SPACE && fasta) begin
          phase_nxt = PH_POST_LABEL;
        end else begin
          phase_nxt = PH_LABEL;
          if (label_count < LABEL_MAX) begin
            label_count_nxt = label_count + LW'(1);
            a_vld           = 1'b1;
            a_res.kind      = K_LABEL;
            a_res.value     = byte_in;
          end
        end
      end
      PH_POST_LABEL: begin
        if (byte_in == CH_NL) phase_nxt = PH_SEQ;
      end
      PH_SEQ: begin
        if (byte_in == CH_SPACE || byte_in == CH_NL) begin
          phase_nxt = PH_SEQ;
        end else if (byte_in == CH_GT && fasta) begin
          a_vld            = 1'b1;
          a_res.kind       = K_END;
          a_res.seq_length = sat32(seq_count);
          label_count_nxt  = '0;
          seq_count_nxt    = '0;
          qual_count_nxt   = '0;
          phase_nxt        = PH_PRE_LABEL;
        end else if (byte_in == CH_PLUS && !fasta) begin
          phase_nxt = PH_PLUS;
        end else begin
          if (!(&seq_count)) seq_count_nxt = seq_count + COUNT_WIDTH'(1);
          a_vld       = 1'b1;
          a_res.kind  = K_SEQ;
          a_res.value = byte_in;
        end
      end
      PH_PLUS: begin
        if (byte_in == CH_NL) phase_nxt = PH_SCORE;
      end
      PH_SCORE: begin
        if (byte_in == CH_NL) begin
          phase_nxt = PH_SCORE;
        end else if (byte_in == CH_AT && qual_count >= seq_count) begin
          a_vld            = 1'b1;
          a_res.kind       = K_END;
          a_res.seq_length = sat32(seq_count);
          label_count_nxt  = '0;
          seq_count_nxt    = '0;
          qual_count_nxt   = '0;
          phase_nxt        = PH_PRE_LABEL;
        end else if (!(&qual_count)) begin
          qual_count_nxt = qual_count + COUNT_WIDTH'(1);
        end
      end
      PH_DONE, PH_BAD: begin
        phase_nxt  = PH_BAD;
        a_vld      = 1'b1;
        a_res.kind = K_PARSE_ERR;
        fin_ok     = 1'b0;
      end
      default: begin
        phase_nxt  = PH_UNKNOWN;
        a_vld      = 1'b1;
        a_res.kind = K_UNKNOWN;
        fin_ok     = 1'b0;
      end
    endcase

    // Close out the file on its final byte
    if (last_in && fin_ok) begin
      if (phase_nxt == PH_DETECT) begin
        phase_nxt  = PH_UNKNOWN;
        b_vld      = 1'b1;
        b_res.kind = K_UNKNOWN;
      end else if (phase_nxt == PH_PRE_LABEL || phase_nxt == PH_LABEL ||
                   phase_nxt == PH_POST_LABEL || phase_nxt == PH_SEQ ||
                   phase_nxt == PH_PLUS || phase_nxt == PH_SCORE) begin
        b_vld            = 1'b1;
        b_res.kind       = K_END;
        b_res.seq_length = sat32(seq_count_nxt);
        label_count_nxt  = '0;
        seq_count_nxt    = '0;
        qual_count_nxt   = '0;
        phase_nxt        = PH_DONE;
      end
    end

    a_res.format = file_kind_nxt;
    b_res.format = file_kind_nxt;

    step_out.num  = {1'b0, a_vld} + {1'b0, b_vld};
    step_out.res0 = a_vld ? a_res : b_res;
    step_out.res1 = b_res;
  end

endmodule

`default_nettype wire

// ===== rtl/fqp_queue.sv =====
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue; takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module fqp_queue
  import fqp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire step_out_t step_out,
  output logic           has_room,
  output logic           q_valid,
  input  wire logic      q_pop,
  output result_t        q_head
);

  result_t    mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] n_push;
  logic       do_pop;

  assign has_room = (count_r <= 3'd2);
  assign q_valid  = (count_r != 3'd0);
  assign q_head   = mem_r[rd_ptr_r];
  assign do_pop   = q_valid && q_pop;
  assign n_push   = push ? step_out.num : 2'd0;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
    count_nxt  = count_r + {1'b0, n_push} - {2'b00, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_ptr_r] <= step_out.res0;
    if (n_push == 2'd2) mem_r[wr_ptr_r + 2'd1] <= step_out.res1;
  end

endmodule

`default_nettype wire

// ===== rtl/fasta_fastq_record_parser.sv =====
// ----------------------------------------------------------------------------
// FASTA/FASTQ record parser
// Byte-wide streaming parser emitting label, sequence and record-end items.
// ----------------------------------------------------------------------------
// Feed the file one byte per transaction, with in_last on its final byte. The
// first non-space byte picks the format ('>' FASTA, '@' FASTQ, anything else
// unknown, reported on every byte until reset). Each accepted byte yields zero,
// one or two result transactions: label bytes (kept up to LABEL_LIMIT-1 per
// record), sequence bytes, an empty-label marker, and a record end carrying
// the sequence length, clamped to 32 bits. Bytes after the final one report a
// parse error, sticky until reset. The parser updates its state in the cycle a
// byte is accepted and writes the results into a four-entry result queue, so
// one byte is taken every cycle while the queue has room for two results; the
// sustained rate is one byte per cycle as long as results are drained as fast
// as they are produced, and otherwise is set by the single-result-per-cycle
// output port.
// ----------------------------------------------------------------------------
`default_nettype none

module fasta_fastq_record_parser
  import fqp_pkg::*;
#(
  parameter int LABEL_LIMIT = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_req,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_value,
  output logic [31:0]      out_seq_length,
  output logic             out_format
);

  localparam int LW = $clog2(LABEL_LIMIT);

  // Parser state
  phase_t                 phase_r, phase_nxt;
  logic                   file_kind_r, file_kind_nxt;
  logic [LW-1:0]          label_count_r, label_count_nxt;
  logic [COUNT_WIDTH-1:0] seq_count_r, seq_count_nxt;
  logic [COUNT_WIDTH-1:0] qual_count_r, qual_count_nxt;

  step_out_t step_out;
  result_t   head;
  logic      has_room;
  logic      in_fire;

  // Accept a byte only when the queue can take both of its possible results
  assign in_ready = has_room;
  assign in_fire  = in_valid && in_ready;

  fqp_step #(
    .LABEL_LIMIT (LABEL_LIMIT),
    .COUNT_WIDTH (COUNT_WIDTH),
    .LW          (LW)
  ) u_step (
    .byte_in         (in_byte_req),
    .last_in         (in_last),
    .phase           (phase_r),
    .file_kind       (file_kind_r),
    .label_count     (label_count_r),
    .seq_count       (seq_count_r),
    .qual_count      (qual_count_r),
    .phase_nxt       (phase_nxt),
    .file_kind_nxt   (file_kind_nxt),
    .label_count_nxt (label_count_nxt),
    .seq_count_nxt   (seq_count_nxt),
    .qual_count_nxt  (qual_count_nxt),
    .step_out        (step_out)
  );

  // Advance the parser state on every accepted byte; hold otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_DETECT;
      file_kind_r   <= 1'b0;
      label_count_r <= '0;
      seq_count_r   <= '0;
      qual_count_r  <= '0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      file_kind_r   <= file_kind_nxt;
      label_count_r <= label_count_nxt;
      seq_count_r   <= seq_count_nxt;
      qual_count_r  <= qual_count_nxt;
    end
  end

  // Queue the results; the head drives the output channel
  fqp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_fire),
    .step_out (step_out),
    .has_room (has_room),
    .q_valid  (out_valid),
    .q_pop    (out_ready),
    .q_head   (head)
  );

  assign out_kind       = head.kind;
  assign out_value      = head.value;
  assign out_seq_length = head.seq_length;
  assign out_format     = head.format;

endmodule

`default_nettype wire
